// File: rtl/ftls_pkg.sv
// Package for the flat triangle Lambert shader: fixed-point widths,
// light directions and colour constants. No dependencies.
package ftls_pkg;

  localparam int COORD_BITS_DEF = 24;

  localparam int EDGE_SW  = 32;  // scaled edge component, signed
  localparam int PROD_W   = 64;  // edge product, signed
  localparam int CROSS_W  = 65;  // cross component, signed
  localparam int MAG_W    = 64;  // cross magnitude
  localparam int LEN_W    = 7;   // bit length of a cross magnitude
  localparam int NRM_BITS = 30;  // normalised cross magnitude
  localparam int NRM_SW   = 31;  // normalised cross, signed
  localparam int DIR_W    = 16;
  localparam int DPROD_W  = 47;
  localparam int DOT_W    = 49;
  localparam int SQR_W    = 60;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int TRY_W    = 64;
  localparam int NUM_W    = 49;
  localparam int QUO_W    = 18;
  localparam int SHADE_W  = 16;
  localparam int LIGHT_W  = 16;

  localparam logic [SHADE_W-1:0] SHADE_AMBIENT   = 16'd3277;
  localparam logic [14:0]        SHADE_COL_08    = 15'd26214;
  localparam logic [QUO_W-1:0]   SHADE_MAX_LIGHT = 18'd32768;

  typedef logic signed [DIR_W-1:0] dir_t;

  localparam dir_t LIGHT0_DIR [3] = '{16'sd17857, -16'sd25510, 16'sd10204};
  localparam dir_t LIGHT1_DIR [3] = '{-16'sd10204, 16'sd25510, -16'sd17857};

endpackage

// File: rtl/flat_triangle_lambert_shader_unit.sv
// Flat Lambert shader top level: face normal, normalisation, two-light shading.
// Depends on ftls_pkg.
//
// Accepts one triangle every clock (busy never rises) and returns its colour
// on a one-cycle out_valid strobe. The pipeline holds a 31-stage
// bit-per-stage square root of the normal length and an 18-stage
// restoring divider for the two light terms, behind nine arithmetic stages,
// with a numerator stage and an output register besides.
// The receiver cannot stall; results appear in request order.
module flat_triangle_lambert_shader_unit
  import ftls_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_vertex_a_x,
  input  logic signed [COORD_BITS-1:0]  in_vertex_a_y,
  input  logic signed [COORD_BITS-1:0]  in_vertex_a_z,
  input  logic signed [COORD_BITS-1:0]  in_vertex_b_x,
  input  logic signed [COORD_BITS-1:0]  in_vertex_b_y,
  input  logic signed [COORD_BITS-1:0]  in_vertex_b_z,
  input  logic signed [COORD_BITS-1:0]  in_vertex_c_x,
  input  logic signed [COORD_BITS-1:0]  in_vertex_c_y,
  input  logic signed [COORD_BITS-1:0]  in_vertex_c_z,
  output logic                          out_valid,
  output logic [SHADE_W-1:0]            out_shade_red,
  output logic [SHADE_W-1:0]            out_shade_green,
  output logic [SHADE_W-1:0]            out_shade_blue,
  output logic                          out_degenerate
);

  localparam int EW  = COORD_BITS + 1;
  localparam int MW  = (EW > EDGE_SW) ? EW : EDGE_SW;
  localparam int LW  = $clog2(MW + 1);
  localparam int LAT = 10 + ROOT_W + QUO_W + 1;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: edges
  logic                 s1_v_r;
  logic signed [EW-1:0] s1_e_r [6];

  // stage 2: edge range limit
  logic                      s2_v_r;
  logic signed [EDGE_SW-1:0] s2_e_r   [6];
  logic signed [EDGE_SW-1:0] s2_e_nxt [6];
  logic [MW-1:0]             s2_mag   [6];
  logic [MW-1:0]             s2_mor;
  logic [MW-1:0]             s2_q;
  logic [LW-1:0]             s2_len;
  logic [LW-1:0]             s2_sh;

  // stage 3: products
  logic                     s3_v_r;
  logic signed [PROD_W-1:0] s3_p_r [6];

  // stage 4: cross
  logic                      s4_v_r;
  logic signed [CROSS_W-1:0] s4_c_r [3];

  // stage 5: magnitudes
  logic             s5_v_r;
  logic             s5_deg_r;
  logic [MAG_W-1:0] s5_m_r   [3];
  logic [2:0]       s5_neg_r;
  logic [MAG_W-1:0] s5_or_r;
  logic [MAG_W-1:0] s5_m_nxt [3];

  // stage 6: bit length
  logic             s6_v_r;
  logic             s6_deg_r;
  logic [MAG_W-1:0] s6_m_r [3];
  logic [2:0]       s6_neg_r;
  logic [LEN_W-1:0] s6_len_r;
  logic [LEN_W-1:0] s6_len_nxt;

  // stage 7: normalise
  logic                     s7_v_r;
  logic                     s7_deg_r;
  logic [NRM_BITS-1:0]      s7_n_r   [3];
  logic signed [NRM_SW-1:0] s7_c_r   [3];
  logic [NRM_BITS-1:0]      s7_n_nxt [3];
  logic [MAG_W-1:0]         s7_t     [3];

  // stage 8: squares and light products
  logic                      s8_v_r;
  logic                      s8_deg_r;
  logic [SQR_W-1:0]          s8_sq_r [3];
  logic signed [DPROD_W-1:0] s8_p0_r [3];
  logic signed [DPROD_W-1:0] s8_p1_r [3];

  // square root pipeline, entry 0 holds the sums
  logic                    sq_v_r    [ROOT_W+1];
  logic                    sq_deg_r  [ROOT_W+1];
  logic [TRY_W-1:0]        sq_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]       sq_root_r [ROOT_W+1];
  logic signed [DOT_W-1:0] sq_d0_r   [ROOT_W+1];
  logic signed [DOT_W-1:0] sq_d1_r   [ROOT_W+1];
  logic [TRY_W-1:0]        sq_rem_nxt  [ROOT_W+1];
  logic [ROOT_W-1:0]       sq_root_nxt [ROOT_W+1];
  logic [TRY_W-1:0]        sq_try      [ROOT_W+1];

  // divider pipeline, entry 0 holds the numerators
  logic              dv_v_r   [QUO_W+1];
  logic              dv_deg_r [QUO_W+1];
  logic [ROOT_W-1:0] dv_r_r   [QUO_W+1];
  logic [NUM_W-1:0]  dv_n0_r  [QUO_W+1];
  logic [NUM_W-1:0]  dv_n1_r  [QUO_W+1];
  logic [QUO_W-1:0]  dv_q0_r  [QUO_W+1];
  logic [QUO_W-1:0]  dv_q1_r  [QUO_W+1];
  logic [NUM_W-1:0]  dv_n0_nxt [QUO_W+1];
  logic [NUM_W-1:0]  dv_n1_nxt [QUO_W+1];
  logic [QUO_W-1:0]  dv_q0_nxt [QUO_W+1];
  logic [QUO_W-1:0]  dv_q1_nxt [QUO_W+1];
  logic [NUM_W-1:0]  dv_div    [QUO_W+1];

  // output stage
  logic [LIGHT_W-1:0] fn_l0;
  logic [LIGHT_W-1:0] fn_l1;
  logic [LIGHT_W-1:0] fn_t0;
  logic [LIGHT_W-1:0] fn_t1;
  logic [31:0]        fn_m1;
  logic [LIGHT_W-1:0] fn_b1;
  logic [SHADE_W-1:0] red_nxt;
  logic [SHADE_W-1:0] blue_nxt;

  // ---------------- combinational ----------------
  always_comb begin
    s2_mor = '0;
    for (int k = 0; k < 6; k++) begin
      s2_mag[k] = MW'($unsigned(s1_e_r[k][EW-1] ? -s1_e_r[k] : s1_e_r[k]));
      s2_mor    = s2_mor | s2_mag[k];
    end
    s2_len = '0;
    for (int b = 0; b < MW; b++) begin
      if (s2_mor[b]) begin
        s2_len = LW'(b + 1);
      end
    end
    s2_sh = (s2_len > LW'(EDGE_SW - 1)) ? s2_len - LW'(EDGE_SW - 1) : '0;
    s2_q  = '0;
    for (int k = 0; k < 6; k++) begin
      s2_q        = s2_mag[k] >> s2_sh;
      s2_e_nxt[k] = s1_e_r[k][EW-1] ? -$signed({1'b0, s2_q[EDGE_SW-2:0]})
                                    :  $signed({1'b0, s2_q[EDGE_SW-2:0]});
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s5_m_nxt[k] = s4_c_r[k][CROSS_W-1] ? MAG_W'(-s4_c_r[k]) : MAG_W'(s4_c_r[k]);
    end
  end

  always_comb begin
    s6_len_nxt = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (s5_or_r[b]) begin
        s6_len_nxt = LEN_W'(b + 1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s6_len_r > LEN_W'(NRM_BITS)) begin
        s7_t[k] = s6_m_r[k] >> (s6_len_r - LEN_W'(NRM_BITS));
      end else begin
        s7_t[k] = s6_m_r[k] << (LEN_W'(NRM_BITS) - s6_len_r);
      end
      s7_n_nxt[k] = s7_t[k][NRM_BITS-1:0];
    end
  end

  always_comb begin
    sq_rem_nxt[0]  = '0;
    sq_root_nxt[0] = '0;
    sq_try[0]      = '0;
    for (int j = 1; j <= ROOT_W; j++) begin
      sq_try[j] = (TRY_W'(sq_root_r[j-1]) << (ROOT_W - j + 1))
                + (TRY_W'(1) << (2 * (ROOT_W - j)));
      if (sq_rem_r[j-1] >= sq_try[j]) begin
        sq_rem_nxt[j]  = sq_rem_r[j-1] - sq_try[j];
        sq_root_nxt[j] = sq_root_r[j-1] | (ROOT_W'(1) << (ROOT_W - j));
      end else begin
        sq_rem_nxt[j]  = sq_rem_r[j-1];
        sq_root_nxt[j] = sq_root_r[j-1];
      end
    end
  end

  always_comb begin
    dv_n0_nxt[0] = (sq_d0_r[ROOT_W] > 0) ? NUM_W'($unsigned(sq_d0_r[ROOT_W])) : '0;
    dv_n1_nxt[0] = (sq_d1_r[ROOT_W] > 0) ? NUM_W'($unsigned(sq_d1_r[ROOT_W])) : '0;
    dv_q0_nxt[0] = '0;
    dv_q1_nxt[0] = '0;
    dv_div[0]    = '0;
    for (int j = 1; j <= QUO_W; j++) begin
      dv_div[j]    = NUM_W'(dv_r_r[j-1]) << (QUO_W - j);
      dv_n0_nxt[j] = dv_n0_r[j-1];
      dv_q0_nxt[j] = dv_q0_r[j-1];
      dv_n1_nxt[j] = dv_n1_r[j-1];
      dv_q1_nxt[j] = dv_q1_r[j-1];
      if (dv_n0_r[j-1] >= dv_div[j]) begin
        dv_n0_nxt[j] = dv_n0_r[j-1] - dv_div[j];
        dv_q0_nxt[j] = dv_q0_r[j-1] | (QUO_W'(1) << (QUO_W - j));
      end
      if (dv_n1_r[j-1] >= dv_div[j]) begin
        dv_n1_nxt[j] = dv_n1_r[j-1] - dv_div[j];
        dv_q1_nxt[j] = dv_q1_r[j-1] | (QUO_W'(1) << (QUO_W - j));
      end
    end
  end

  // a degenerate face has a zero root, so its quotients are meaningless
  always_comb begin
    if (dv_deg_r[QUO_W]) begin
      fn_l0 = '0;
      fn_l1 = '0;
    end else begin
      fn_l0 = (dv_q0_r[QUO_W] > SHADE_MAX_LIGHT) ? LIGHT_W'(SHADE_MAX_LIGHT)
                                                 : LIGHT_W'(dv_q0_r[QUO_W]);
      fn_l1 = (dv_q1_r[QUO_W] > SHADE_MAX_LIGHT) ? LIGHT_W'(SHADE_MAX_LIGHT)
                                                 : LIGHT_W'(dv_q1_r[QUO_W]);
    end
    fn_t0 = LIGHT_W'((17'(fn_l0) + 17'd1) >> 1);
    fn_t1 = LIGHT_W'((17'(fn_l1) + 17'd1) >> 1);
    fn_m1 = 32'(fn_l1) * 32'(SHADE_COL_08) + 32'd32768;
    fn_b1 = fn_m1[31:16];
    red_nxt  = SHADE_AMBIENT + fn_t0 + fn_t1;
    blue_nxt = SHADE_AMBIENT + fn_t0 + fn_b1;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      s6_v_r    <= 1'b0;
      s7_v_r    <= 1'b0;
      s8_v_r    <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j <= ROOT_W; j++) begin
        sq_v_r[j] <= 1'b0;
      end
      for (int j = 0; j <= QUO_W; j++) begin
        dv_v_r[j] <= 1'b0;
      end
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
      sq_v_r[0] <= s8_v_r;
      for (int j = 1; j <= ROOT_W; j++) begin
        sq_v_r[j] <= sq_v_r[j-1];
      end
      dv_v_r[0] <= sq_v_r[ROOT_W];
      for (int j = 1; j <= QUO_W; j++) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
      out_valid <= dv_v_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    s1_e_r[0] <= EW'(in_vertex_b_x) - EW'(in_vertex_c_x);
    s1_e_r[1] <= EW'(in_vertex_b_y) - EW'(in_vertex_c_y);
    s1_e_r[2] <= EW'(in_vertex_b_z) - EW'(in_vertex_c_z);
    s1_e_r[3] <= EW'(in_vertex_c_x) - EW'(in_vertex_a_x);
    s1_e_r[4] <= EW'(in_vertex_c_y) - EW'(in_vertex_a_y);
    s1_e_r[5] <= EW'(in_vertex_c_z) - EW'(in_vertex_a_z);

    s2_e_r <= s2_e_nxt;

    s3_p_r[0] <= PROD_W'(s2_e_r[1]) * PROD_W'(s2_e_r[5]);
    s3_p_r[1] <= PROD_W'(s2_e_r[2]) * PROD_W'(s2_e_r[4]);
    s3_p_r[2] <= PROD_W'(s2_e_r[2]) * PROD_W'(s2_e_r[3]);
    s3_p_r[3] <= PROD_W'(s2_e_r[0]) * PROD_W'(s2_e_r[5]);
    s3_p_r[4] <= PROD_W'(s2_e_r[0]) * PROD_W'(s2_e_r[4]);
    s3_p_r[5] <= PROD_W'(s2_e_r[1]) * PROD_W'(s2_e_r[3]);

    s4_c_r[0] <= CROSS_W'(s3_p_r[0]) - CROSS_W'(s3_p_r[1]);
    s4_c_r[1] <= CROSS_W'(s3_p_r[2]) - CROSS_W'(s3_p_r[3]);
    s4_c_r[2] <= CROSS_W'(s3_p_r[4]) - CROSS_W'(s3_p_r[5]);

    s5_m_r   <= s5_m_nxt;
    s5_or_r  <= s5_m_nxt[0] | s5_m_nxt[1] | s5_m_nxt[2];
    s5_neg_r <= {s4_c_r[2][CROSS_W-1], s4_c_r[1][CROSS_W-1], s4_c_r[0][CROSS_W-1]};
    s5_deg_r <= (s4_c_r[0] == '0) && (s4_c_r[1] == '0) && (s4_c_r[2] == '0);

    s6_m_r   <= s5_m_r;
    s6_neg_r <= s5_neg_r;
    s6_deg_r <= s5_deg_r;
    s6_len_r <= s6_len_nxt;

    s7_n_r   <= s7_n_nxt;
    s7_deg_r <= s6_deg_r;
    for (int k = 0; k < 3; k++) begin
      s7_c_r[k] <= s6_neg_r[k] ? -$signed({1'b0, s7_n_nxt[k]}) : $signed({1'b0, s7_n_nxt[k]});
    end

    s8_deg_r <= s7_deg_r;
    for (int k = 0; k < 3; k++) begin
      s8_sq_r[k] <= SQR_W'(s7_n_r[k]) * SQR_W'(s7_n_r[k]);
      s8_p0_r[k] <= DPROD_W'(s7_c_r[k]) * DPROD_W'(LIGHT0_DIR[k]);
      s8_p1_r[k] <= DPROD_W'(s7_c_r[k]) * DPROD_W'(LIGHT1_DIR[k]);
    end

    sq_rem_r[0]  <= TRY_W'(SUM_W'(s8_sq_r[0]) + SUM_W'(s8_sq_r[1]) + SUM_W'(s8_sq_r[2]));
    sq_root_r[0] <= '0;
    sq_deg_r[0]  <= s8_deg_r;
    sq_d0_r[0]   <= DOT_W'(s8_p0_r[0]) + DOT_W'(s8_p0_r[1]) + DOT_W'(s8_p0_r[2]);
    sq_d1_r[0]   <= DOT_W'(s8_p1_r[0]) + DOT_W'(s8_p1_r[1]) + DOT_W'(s8_p1_r[2]);
    for (int j = 1; j <= ROOT_W; j++) begin
      sq_rem_r[j]  <= sq_rem_nxt[j];
      sq_root_r[j] <= sq_root_nxt[j];
      sq_deg_r[j]  <= sq_deg_r[j-1];
      sq_d0_r[j]   <= sq_d0_r[j-1];
      sq_d1_r[j]   <= sq_d1_r[j-1];
    end

    dv_r_r[0]   <= sq_root_r[ROOT_W];
    dv_deg_r[0] <= sq_deg_r[ROOT_W];
    for (int j = 0; j <= QUO_W; j++) begin
      dv_n0_r[j] <= dv_n0_nxt[j];
      dv_n1_r[j] <= dv_n1_nxt[j];
      dv_q0_r[j] <= dv_q0_nxt[j];
      dv_q1_r[j] <= dv_q1_nxt[j];
    end
    for (int j = 1; j <= QUO_W; j++) begin
      dv_r_r[j]   <= dv_r_r[j-1];
      dv_deg_r[j] <= dv_deg_r[j-1];
    end

    out_shade_red   <= red_nxt;
    out_shade_green <= red_nxt;
    out_shade_blue  <= blue_nxt;
    out_degenerate  <= dv_deg_r[QUO_W];
  end

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching request");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_shade_red == SHADE_AMBIENT) && (out_shade_blue == SHADE_AMBIENT))
    else $error("degenerate triangle not ambient");

  a_blue_le_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shade_blue <= out_shade_red) && (out_shade_red >= SHADE_AMBIENT))
    else $error("channel ordering broken");

endmodule

// File: tb/sv/ftls_checker.sv
// Checker for the flat triangle Lambert shader: watches requests and results,
// predicts each shade and compares in order. Depends on ftls_pkg.
module ftls_checker
  import ftls_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic signed [23:0]  in_vertex_a_x,
  input  logic signed [23:0]  in_vertex_a_y,
  input  logic signed [23:0]  in_vertex_a_z,
  input  logic signed [23:0]  in_vertex_b_x,
  input  logic signed [23:0]  in_vertex_b_y,
  input  logic signed [23:0]  in_vertex_b_z,
  input  logic signed [23:0]  in_vertex_c_x,
  input  logic signed [23:0]  in_vertex_c_y,
  input  logic signed [23:0]  in_vertex_c_z,
  input  logic                out_valid,
  input  logic [SHADE_W-1:0]  out_shade_red,
  input  logic [SHADE_W-1:0]  out_shade_green,
  input  logic [SHADE_W-1:0]  out_shade_blue,
  input  logic                out_degenerate,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        degen;
  } shade_t;

  shade_t shade_q[$];

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic int bitlen(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic shade_t predict_shade(longint a[3], longint b[3], longint c[3]);
    longint e1[3], e2[3], cr[3], d;
    longint unsigned m, s, r, q, acc, am;
    longint unsigned lt[2];
    longint dir[2][3];
    longint unsigned col[2][3];
    int len;
    shade_t res;
    dir = '{'{17857, -25510, 10204}, '{-10204, 25510, -17857}};
    col = '{'{32768, 32768, 32768}, '{32768, 32768, 26214}};
    for (int k = 0; k < 3; k++) begin
      e1[k] = b[k] - c[k];
      e2[k] = c[k] - a[k];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      res.red = SHADE_AMBIENT;
      res.green = SHADE_AMBIENT;
      res.blue = SHADE_AMBIENT;
      res.degen = 1'b1;
      return res;
    end
    m = 0;
    for (int k = 0; k < 3; k++) if (mag(cr[k]) > m) m = mag(cr[k]);
    len = bitlen(m);
    s = 0;
    for (int k = 0; k < 3; k++) begin
      am = mag(cr[k]);
      if (len > 30) am >>= (len - 30);
      else am <<= (30 - len);
      cr[k] = (cr[k] < 0) ? -longint'(am) : longint'(am);
      s += am * am;
    end
    r = int_sqrt(s);
    for (int li = 0; li < 2; li++) begin
      d = 0;
      for (int k = 0; k < 3; k++) d += cr[k] * dir[li][k];
      if (d <= 0 || r == 0) lt[li] = 0;
      else begin
        q = longint'(d) / r;
        lt[li] = (q > 32768) ? 32768 : q;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = SHADE_AMBIENT;
      for (int li = 0; li < 2; li++) acc += (lt[li] * col[li][ch] + 32768) >> 16;
      if (acc > 65535) acc = 65535;
      if (ch == 0) res.red = acc[15:0];
      else if (ch == 1) res.green = acc[15:0];
      else res.blue = acc[15:0];
    end
    res.degen = 1'b0;
    return res;
  endfunction

  assign pending = shade_q.size();

  always @(posedge clk) begin
    shade_t want, got;
    longint va[3], vb[3], vc[3];
    if (!rst_n) begin
      fail_count <= 0;
      shade_q.delete();
    end else begin
      if (out_valid) begin
        got = '{out_shade_red, out_shade_green, out_shade_blue, out_degenerate};
        if (shade_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = shade_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("shade mismatch: exp r=%0d g=%0d b=%0d d=%0d got r=%0d g=%0d b=%0d d=%0d",
                       want.red, want.green, want.blue, want.degen,
                       got.red, got.green, got.blue, got.degen);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        va = '{in_vertex_a_x, in_vertex_a_y, in_vertex_a_z};
        vb = '{in_vertex_b_x, in_vertex_b_y, in_vertex_b_z};
        vc = '{in_vertex_c_x, in_vertex_c_y, in_vertex_c_z};
        shade_q.push_back(predict_shade(va, vb, vc));
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for flat_triangle_lambert_shader_unit: drives triangles with
// random gaps and gives the verdict. Depends on ftls_pkg and ftls_checker.
module tb_top;
  import ftls_pkg::*;

  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] vtx [9];
  logic out_valid, out_degenerate;
  logic [SHADE_W-1:0] out_shade_red, out_shade_green, out_shade_blue;
  int fail_count, pending;

  initial for (int i = 0; i < 9; i++) vtx[i] = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  flat_triangle_lambert_shader_unit dut (
    .clk, .rst_n, .start, .busy,
    .in_vertex_a_x(vtx[0]), .in_vertex_a_y(vtx[1]), .in_vertex_a_z(vtx[2]),
    .in_vertex_b_x(vtx[3]), .in_vertex_b_y(vtx[4]), .in_vertex_b_z(vtx[5]),
    .in_vertex_c_x(vtx[6]), .in_vertex_c_y(vtx[7]), .in_vertex_c_z(vtx[8]),
    .out_valid, .out_shade_red, .out_shade_green, .out_shade_blue, .out_degenerate
  );

  ftls_checker chk (
    .clk, .rst_n, .start, .busy,
    .in_vertex_a_x(vtx[0]), .in_vertex_a_y(vtx[1]), .in_vertex_a_z(vtx[2]),
    .in_vertex_b_x(vtx[3]), .in_vertex_b_y(vtx[4]), .in_vertex_b_z(vtx[5]),
    .in_vertex_c_x(vtx[6]), .in_vertex_c_y(vtx[7]), .in_vertex_c_z(vtx[8]),
    .out_valid, .out_shade_red, .out_shade_green, .out_shade_blue, .out_degenerate,
    .fail_count, .pending
  );

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return $signed(24'($urandom()));
      1: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
      2: return ($urandom_range(0, 1)) ? CMAX : CMIN;
      default: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
    endcase
  endfunction

  // holds the request until accepted; gap decides whether start drops after
  task automatic send_triangle(logic signed [23:0] v [9], bit gap);
    int n;
    start <= 1'b1;
    for (int i = 0; i < 9; i++) vtx[i] <= v[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap) begin
      start <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_last();
    start <= 1'b0;
  endtask

  initial begin
    logic signed [23:0] v [9];
    int mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zeros, extremes, collinear, coincident, axis faces both ways
    v = '{default: 24'sd0};                                   send_triangle(v, 0);
    v = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX}; send_triangle(v, 0);
    v = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX}; send_triangle(v, 0);
    v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0};       send_triangle(v, 0);
    v = '{256, 512, 768, 256, 512, 768, 256, 512, 768};        send_triangle(v, 0);
    v = '{0, 0, 0, 256, 0, 0, 512, 0, 0};                      send_triangle(v, 0);
    v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};                      send_triangle(v, 0);
    v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};                      send_triangle(v, 0);
    v = '{0, 0, 0, 0, 0, 256, 0, 256, 0};                      send_triangle(v, 0);
    v = '{0, 0, 0, 0, 256, 0, 0, 0, 256};                      send_triangle(v, 1);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                          send_triangle(v, 0);
    v = '{CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX};                 send_triangle(v, 0);
    v = '{CMAX, 0, 0, 0, 0, CMAX, 0, CMAX, 0};                 send_triangle(v, 0);
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};                 send_triangle(v, 1);
    // random: the last part runs without gaps
    for (int t = 0; t < 450; t++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) v[i] = rand_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
      end
      send_triangle(v, (t < 350) && ($urandom_range(0, 3) == 0));
    end
    send_last();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
